### src/tboq_pkg.sv
package tboq_pkg;

  localparam int unsigned DEF_MAX_TASKS = 8;

  // list codes
  localparam logic [1:0] LIST_IN_PORT  = 2'd0;
  localparam logic [1:0] LIST_IN_HOLD  = 2'd1;
  localparam logic [1:0] LIST_OUT_PORT = 2'd2;
  localparam logic [1:0] LIST_OUT_HOLD = 2'd3;

  // operation codes
  localparam logic [1:0] OP_POLL    = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_ENQUEUE = 2'd2;
  localparam logic [1:0] OP_MOVE    = 2'd3;

  // result codes
  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_NOT_READY = 2'd1;
  localparam logic [1:0] RC_EMPTY     = 2'd2;
  localparam logic [1:0] RC_BAD_INDEX = 2'd3;

  // config register indexes
  localparam logic [0:0] REG_POOL_SIZE   = 1'b0;
  localparam logic [0:0] REG_QUEUE_READY = 1'b1;

endpackage

### src/task_buffer_ownership_queue.sv
// Results: a poll or a rejected operation is strobed in the cycle after its accepting
//   edge; dequeue, enqueue and move are strobed once their relink steps are done.
// Throughput: polls and rejects can follow every cycle while no config write is pending;
//   a relink holds busy for load, read/write of prev, next and tail, then own write.
// Reset (rst, synchronous, active high) or any configuration write rebuilds the
//   lists by a sweep over all MAX_TASKS slots; busy is high during the sweep.
// The receiver cannot stall: done is high for exactly one cycle per operation.
module task_buffer_ownership_queue
  import tboq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic       port,
  input  logic [2:0] task_index,
  input  logic [1:0] target_list,
  output logic       done,
  output logic [1:0] result_code,
  output logic [2:0] result_task,
  output logic [3:0] list_count,
  output logic       hold_mismatch,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  // Per-task link entry; link words carry a valid flag in place of a null code.
  typedef struct packed {
    logic [1:0]    owner;
    logic          nxt_ok;
    logic [TW-1:0] nxt;
    logic          prv_ok;
    logic [TW-1:0] prv;
  } entry_t;

  typedef enum logic [9:0] {
    ST_INIT    = 10'b00_0000_0001,
    ST_IDLE    = 10'b00_0000_0010,
    ST_LOAD    = 10'b00_0000_0100,
    ST_PREV_RD = 10'b00_0000_1000,
    ST_PREV_WR = 10'b00_0001_0000,
    ST_NEXT_RD = 10'b00_0010_0000,
    ST_NEXT_WR = 10'b00_0100_0000,
    ST_TAIL_RD = 10'b00_1000_0000,
    ST_TAIL_WR = 10'b01_0000_0000,
    ST_SELF_WR = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Entry memory: single port, registered synchronous read. Every neighbour
  // patch is a read step followed by a write step, so no access overlaps.
  entry_t        mem [MAX_TASKS];
  entry_t        rd_entry;
  logic          mem_we;
  logic [TW-1:0] mem_addr;
  entry_t        mem_wdata;
  entry_t        init_entry;

  // List descriptors are four small registers.
  logic          head_ok [4];
  logic [TW-1:0] head    [4];
  logic          tail_ok [4];
  logic [TW-1:0] tail    [4];
  logic [CW-1:0] lsize   [4];

  logic [3:0]    slot_limit;
  logic          queue_ready;
  logic [CW-1:0] eff;
  logic [TW-1:0] sweep;

  // latched operation word
  logic [1:0]    op_q;
  logic          port_q;
  logic [TW-1:0] tsk_q;
  logic [1:0]    tgt_q;
  entry_t        ent_q;     // moving task's entry before unlink

  logic          start_acc;
  logic          cfg_acc;
  logic          done_next;
  logic [1:0]    pl_in;
  logic [1:0]    code_in;
  logic [TW-1:0] tsel_in;
  logic          idx_bad;
  logic          relink_in;
  logic [3:0]    poll_cnt;
  logic [1:0]    hl_q;
  logic [1:0]    dst;

  // counts above MAX_TASKS saturate
  assign eff = (32'(slot_limit) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(slot_limit);

  // a pending config write holds off new words so the two never share an edge
  assign busy      = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE) && !done;
  assign start_acc = start && !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // early decode at accept
  assign pl_in    = port ? LIST_OUT_PORT : LIST_IN_PORT;
  assign idx_bad  = (32'(task_index) >= 32'(eff));
  assign tsel_in  = (operation == OP_DEQUEUE) ? head[pl_in] : TW'(task_index);
  assign poll_cnt = (32'(lsize[pl_in]) > 32'd15) ? 4'd15 : 4'(lsize[pl_in]);

  always_comb begin
    if (!queue_ready) code_in = RC_NOT_READY;
    else if (operation == OP_POLL) code_in = (lsize[pl_in] == '0) ? RC_EMPTY : RC_OK;
    else if (operation == OP_DEQUEUE)
      code_in = (lsize[pl_in] == '0 || !head_ok[pl_in]) ? RC_EMPTY : RC_OK;
    else if (idx_bad) code_in = RC_BAD_INDEX;
    else code_in = RC_OK;
  end

  // only successful dequeue, enqueue and move touch the lists
  assign relink_in = (code_in == RC_OK) && (operation != OP_POLL);
  assign done_next = (start_acc && !relink_in) || (state == ST_SELF_WR);

  // destination list of the moving task
  assign hl_q = port_q ? LIST_OUT_HOLD : LIST_IN_HOLD;
  always_comb begin
    unique case (op_q)
      OP_DEQUEUE: dst = hl_q;
      OP_ENQUEUE: dst = port_q ? LIST_IN_PORT : LIST_OUT_PORT;
      default:    dst = tgt_q;
    endcase
  end

  // sweep entry: slots below the count chained in index order
  always_comb begin
    init_entry.owner  = LIST_IN_PORT;
    init_entry.nxt_ok = (32'(sweep) + 32'd1 < 32'(eff));
    init_entry.nxt    = sweep + TW'(1);
    init_entry.prv_ok = (sweep != '0) && (32'(sweep) < 32'(eff));
    init_entry.prv    = sweep - TW'(1);
  end

  // memory port: address, write enable and merged write data per step
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = tsel_in;
    mem_wdata = rd_entry;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = sweep;
        mem_wdata = init_entry;
      end
      ST_PREV_RD: mem_addr = ent_q.prv;
      ST_PREV_WR: begin
        // prev.next = next
        mem_we           = ent_q.prv_ok;
        mem_addr         = ent_q.prv;
        mem_wdata.nxt_ok = ent_q.nxt_ok;
        mem_wdata.nxt    = ent_q.nxt;
      end
      ST_NEXT_RD: mem_addr = ent_q.nxt;
      ST_NEXT_WR: begin
        // next.prev = prev
        mem_we           = ent_q.nxt_ok;
        mem_addr         = ent_q.nxt;
        mem_wdata.prv_ok = ent_q.prv_ok;
        mem_wdata.prv    = ent_q.prv;
      end
      ST_TAIL_RD: mem_addr = tail[dst];
      ST_TAIL_WR: begin
        // old tail of dst (after unlink) points at the moving task
        mem_we           = tail_ok[dst];
        mem_addr         = tail[dst];
        mem_wdata.nxt_ok = 1'b1;
        mem_wdata.nxt    = tsk_q;
      end
      ST_SELF_WR: begin
        mem_we           = 1'b1;
        mem_addr         = tsk_q;
        mem_wdata.owner  = dst;
        mem_wdata.nxt_ok = 1'b0;
        mem_wdata.nxt    = '0;
        mem_wdata.prv_ok = tail_ok[dst];
        mem_wdata.prv    = tail[dst];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_entry <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
      slot_limit <= 4'd8;
      queue_ready <= 1'b0;
      done <= 1'b0;
      result_code <= RC_OK;
      result_task <= 3'd0;
      list_count <= 4'd0;
      hold_mismatch <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        ST_INIT: begin
          if (sweep == '0) begin
            for (int l = 0; l < 4; l++) begin
              head_ok[l] <= (l == 0) && (eff != '0);
              head[l]    <= '0;
              tail_ok[l] <= (l == 0) && (eff != '0);
              tail[l]    <= TW'(eff - CW'(1));
              lsize[l]   <= (l == 0) ? eff : '0;
            end
          end
          if (32'(sweep) == MAX_TASKS - 1) begin
            state <= ST_IDLE;
            sweep <= '0;
          end else begin
            sweep <= sweep + TW'(1);
          end
        end
        ST_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == REG_POOL_SIZE) slot_limit <= cfg_data;
            else queue_ready <= cfg_data[0];
            state <= ST_INIT;
          end else if (start_acc) begin
            op_q <= operation;
            port_q <= port;
            tsk_q <= tsel_in;
            tgt_q <= target_list;
            if (relink_in) begin
              state <= ST_LOAD;
            end else begin
              // poll or reject: answer straight away
              result_code <= code_in;
              result_task <= 3'd0;
              list_count <= (code_in == RC_OK) ? poll_cnt : 4'd0;
              hold_mismatch <= 1'b0;
            end
          end
        end
        ST_LOAD: begin
          // unlink from the source list descriptors
          ent_q <= rd_entry;
          if (!rd_entry.prv_ok) begin
            head_ok[rd_entry.owner] <= rd_entry.nxt_ok;
            head[rd_entry.owner] <= rd_entry.nxt;
          end
          if (!rd_entry.nxt_ok) begin
            tail_ok[rd_entry.owner] <= rd_entry.prv_ok;
            tail[rd_entry.owner] <= rd_entry.prv;
          end
          lsize[rd_entry.owner] <= (lsize[rd_entry.owner] != '0) ?
                                   lsize[rd_entry.owner] - CW'(1) : '0;
          state <= ST_PREV_RD;
        end
        ST_PREV_RD: state <= ST_PREV_WR;
        ST_PREV_WR: state <= ST_NEXT_RD;
        ST_NEXT_RD: state <= ST_NEXT_WR;
        ST_NEXT_WR: state <= ST_TAIL_RD;
        ST_TAIL_RD: state <= ST_TAIL_WR;
        ST_TAIL_WR: state <= ST_SELF_WR;
        ST_SELF_WR: begin
          // append at the tail of dst
          if (!tail_ok[dst]) begin
            head_ok[dst] <= 1'b1;
            head[dst] <= tsk_q;
          end
          tail_ok[dst] <= 1'b1;
          tail[dst] <= tsk_q;
          lsize[dst] <= lsize[dst] + CW'(1);
          result_code <= RC_OK;
          result_task <= (op_q == OP_DEQUEUE) ? 3'(tsk_q) : 3'd0;
          list_count <= 4'd0;
          hold_mismatch <= (op_q == OP_ENQUEUE) && (ent_q.owner != hl_q);
          state <= ST_IDLE;
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  property p_done_after_relink;
    @(posedge clk) disable iff (rst) (state == ST_SELF_WR) |=> done;
  endproperty
  a_done_after_relink: assert property (p_done_after_relink) else $error("missing result");

  property p_accept_path;
    @(posedge clk) disable iff (rst) start_acc |=> (done || (state == ST_LOAD));
  endproperty
  a_accept_path: assert property (p_accept_path) else $error("accept lost");

  property p_cfg_rebuild;
    @(posedge clk) disable iff (rst) cfg_acc |=> (state == ST_INIT);
  endproperty
  a_cfg_rebuild: assert property (p_cfg_rebuild) else $error("config write without rebuild");

  property p_state_onehot;
    @(posedge clk) disable iff (rst) $onehot(state);
  endproperty
  a_state_onehot: assert property (p_state_onehot) else $error("state not one-hot");

endmodule

### dv/tboq_checker.sv
`timescale 1ns / 100ps

module tboq_checker
  import tboq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] operation,
  input  logic       port,
  input  logic [2:0] task_index,
  input  logic [1:0] target_list,
  input  logic       done,
  input  logic [1:0] result_code,
  input  logic [2:0] result_task,
  input  logic [3:0] list_count,
  input  logic       hold_mismatch,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         words_seen
);

  localparam logic [3:0] NIL = 4'hF;

  typedef struct packed {
    logic [1:0] code;
    logic [2:0] slot;
    logic [3:0] cnt;
    logic       mism;
  } outcome_t;

  outcome_t   expected_q[$];
  logic [3:0] slots_cfg;
  logic       ready_cfg;
  logic [1:0] owner[8];
  logic [3:0] nxt[8];
  logic [3:0] prv[8];
  logic [3:0] head[4];
  logic [3:0] tail[4];
  int         size[4];

  function automatic int live_slots();
    return (slots_cfg > 8) ? 8 : int'(slots_cfg);
  endfunction

  task automatic rebuild();
    int n;
    n = live_slots();
    for (int i = 0; i < 4; i++) begin
      head[i] = NIL;
      tail[i] = NIL;
      size[i] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      owner[i] = LIST_IN_PORT;
      nxt[i] = (i + 1 < n) ? 4'(i + 1) : NIL;
      prv[i] = (i > 0 && i < n) ? 4'(i - 1) : NIL;
    end
    if (n > 0) begin
      head[0] = 4'd0;
      tail[0] = 4'(n - 1);
      size[0] = n;
    end
  endtask

  task automatic detach(int t);
    logic [1:0] l;
    logic [3:0] p, q;
    l = owner[t];
    p = prv[t];
    q = nxt[t];
    if (p == NIL) head[l] = q; else nxt[p[2:0]] = q;
    if (q == NIL) tail[l] = p; else prv[q[2:0]] = p;
    if (size[l] > 0) size[l]--;
    nxt[t] = NIL;
    prv[t] = NIL;
  endtask

  task automatic attach(int t, logic [1:0] l);
    logic [3:0] tl;
    tl = tail[l];
    prv[t] = tl;
    nxt[t] = NIL;
    if (tl == NIL) head[l] = 4'(t); else nxt[tl[2:0]] = 4'(t);
    tail[l] = 4'(t);
    size[l]++;
    owner[t] = l;
  endtask

  task automatic predict_word(logic [1:0] op, logic prt, logic [2:0] idx, logic [1:0] tgt);
    outcome_t   r;
    logic [1:0] pl, hl;
    int         h;
    r = '0;
    r.code = RC_OK;
    pl = prt ? LIST_OUT_PORT : LIST_IN_PORT;
    hl = prt ? LIST_OUT_HOLD : LIST_IN_HOLD;
    if (!ready_cfg) begin
      r.code = RC_NOT_READY;
    end else if (op == OP_POLL) begin
      if (size[pl] == 0) r.code = RC_EMPTY;
      else r.cnt = (size[pl] > 15) ? 4'd15 : 4'(size[pl]);
    end else if (op == OP_DEQUEUE) begin
      if (size[pl] == 0 || head[pl] == NIL) begin
        r.code = RC_EMPTY;
      end else begin
        h = int'(head[pl][2:0]);
        detach(h);
        attach(h, hl);
        r.slot = 3'(h);
      end
    end else if (int'(idx) >= live_slots()) begin
      r.code = RC_BAD_INDEX;
    end else if (op == OP_ENQUEUE) begin
      r.mism = (owner[idx] != hl);
      detach(idx);
      attach(idx, prt ? LIST_IN_PORT : LIST_OUT_PORT);
    end else begin
      detach(idx);
      attach(idx, tgt);
    end
    expected_q.push_back(r);
  endtask

  task automatic report(string what, int got, int want);
    fail_count++;
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    outcome_t w;
    if (rst) begin
      slots_cfg = 4'd8;
      ready_cfg = 1'b0;
      rebuild();
      expected_q.delete();
      fail_count = 0;
      words_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POOL_SIZE) slots_cfg = cfg_data;
        else ready_cfg = cfg_data[0];
        rebuild();
      end
      if (start && !busy) begin
        predict_word(operation, port, task_index, target_list);
        words_seen <= words_seen + 1;
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          report("unexpected result word, code", result_code, 0);
        end else begin
          w = expected_q.pop_front();
          if (result_code != w.code) report("result_code", result_code, w.code);
          if (result_task != w.slot) report("result_task", result_task, w.slot);
          if (list_count != w.cnt) report("list_count", list_count, w.cnt);
          if (hold_mismatch != w.mism) report("hold_mismatch", hold_mismatch, w.mism);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### dv/tb_task_buffer_ownership_queue.sv
`timescale 1ns / 100ps

module tb_task_buffer_ownership_queue;
  import tboq_pkg::*;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] operation;
  logic       port;
  logic [2:0] task_index;
  logic [1:0] target_list;
  logic       done;
  logic [1:0] result_code;
  logic [2:0] result_task;
  logic [3:0] list_count;
  logic       hold_mismatch;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [3:0] cfg_data;
  int         fail_count;
  int         pending;
  int         words_seen;

  task_buffer_ownership_queue uut (.*);

  tboq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: a run that hangs ends with a mismatch message.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // One word: raise start until busy is low at an edge (accept). start stays
  // high on return so the next word can follow with no gap.
  task automatic send_word(logic [1:0] op, logic prt, logic [2:0] idx, logic [1:0] tgt);
    start       <= 1'b1;
    operation   <= op;
    port        <= prt;
    task_index  <= idx;
    target_list <= tgt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Config writes only with the block drained; the extra cycles cover the
  // result pipeline in case a word is still in flight.
  task automatic write_reg(logic idx, logic [3:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random word biased toward in-range slots and useful flows.
  task automatic random_word(int slots);
    logic [1:0] op;
    logic [2:0] idx;
    op  = 2'($urandom_range(0, 3));
    idx = ($urandom_range(0, 9) == 0 || slots == 0) ? 3'($urandom) :
          3'($urandom_range(0, slots - 1));
    send_word(op, 1'($urandom), idx, 2'($urandom));
  endtask

  // Bursty sender: random-length bursts, random gaps, some long runs with no gap.
  task automatic random_phase(int words, int slots);
    int burst;
    int n;
    n = 0;
    while (n < words) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && n < words; k++) begin
        random_word(slots);
        n++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  int slot_setting[6] = '{8, 1, 15, 3, 0, 5};

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_POLL;
    port        = 1'b0;
    task_index  = 3'd0;
    target_list = LIST_IN_PORT;
    cfg_valid   = 1'b0;
    cfg_index   = REG_POOL_SIZE;
    cfg_data    = 4'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: not ready first, then every operation and the corner cases.
    send_word(OP_DEQUEUE, 1'b0, 3'd0, LIST_IN_PORT);
    send_word(OP_POLL, 1'b1, 3'd7, LIST_OUT_HOLD);
    write_reg(REG_QUEUE_READY, 4'd1);
    send_word(OP_POLL, 1'b0, 3'd0, LIST_IN_PORT);
    send_word(OP_POLL, 1'b1, 3'd0, LIST_IN_PORT);        // empty list
    send_word(OP_DEQUEUE, 1'b1, 3'd0, LIST_IN_PORT);     // empty dequeue
    send_word(OP_DEQUEUE, 1'b0, 3'd0, LIST_IN_PORT);
    send_word(OP_DEQUEUE, 1'b0, 3'd0, LIST_IN_PORT);
    send_word(OP_ENQUEUE, 1'b0, 3'd0, LIST_IN_PORT);     // from hold, clean
    send_word(OP_ENQUEUE, 1'b0, 3'd5, LIST_IN_PORT);     // wrong list
    send_word(OP_POLL, 1'b1, 3'd0, LIST_IN_PORT);
    send_word(OP_DEQUEUE, 1'b1, 3'd0, LIST_IN_PORT);
    send_word(OP_ENQUEUE, 1'b1, 3'd0, LIST_IN_PORT);
    send_word(OP_MOVE, 1'b0, 3'd7, LIST_OUT_HOLD);
    send_word(OP_MOVE, 1'b1, 3'd7, LIST_OUT_HOLD);       // same list, to tail
    send_word(OP_MOVE, 1'b0, 3'd1, LIST_IN_HOLD);
    send_word(OP_MOVE, 1'b0, 3'd2, LIST_OUT_PORT);
    write_reg(REG_POOL_SIZE, 4'd3);
    send_word(OP_MOVE, 1'b0, 3'd3, LIST_IN_HOLD);        // bad index
    send_word(OP_ENQUEUE, 1'b1, 3'd7, LIST_IN_HOLD);     // bad index
    send_word(OP_POLL, 1'b0, 3'd0, LIST_IN_PORT);
    write_reg(REG_POOL_SIZE, 4'd15);                      // saturates to 8
    send_word(OP_POLL, 1'b0, 3'd0, LIST_IN_PORT);
    write_reg(REG_POOL_SIZE, 4'd0);                       // empty pool
    send_word(OP_POLL, 1'b0, 3'd0, LIST_IN_PORT);
    send_word(OP_MOVE, 1'b1, 3'd0, LIST_OUT_PORT);

    // Random phases across several settings; last one drops ready again.
    foreach (slot_setting[i]) begin
      write_reg(REG_POOL_SIZE, 4'(slot_setting[i]));
      write_reg(REG_QUEUE_READY, 4'd1);
      random_phase(280, (slot_setting[i] > 8) ? 8 : slot_setting[i]);
    end
    write_reg(REG_QUEUE_READY, 4'd0);
    random_phase(60, 8);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d operation words over six slot counts, ready on and off.",
             words_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
src/tboq_pkg.sv
src/task_buffer_ownership_queue.sv
dv/tboq_checker.sv
dv/tb_task_buffer_ownership_queue.sv
